### rtl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types and constants for the music priority arbiter.
// ----------------------------------------------------------------------------
package mpa_pkg;

	localparam int NUM_SLOTS_DEF  = 16;
	localparam int NUM_SOUNDS_DEF = 16;

	typedef enum logic [2:0] {
		OP_DEFINE  = 3'd0,
		OP_ADD     = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_TICK    = 3'd3,
		OP_ENABLE  = 3'd4,
		OP_DISABLE = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_PLAY = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CUR    = 5'b00010,
		ST_SLOT   = 5'b00100,
		ST_CAND   = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic        loops;
		logic [15:0] min_play;
		logic [15:0] replay;
		logic [15:0] fade_in;
		logic [15:0] fade_out;
		logic [7:0]  rank;
	} attr_t;

endpackage

### rtl/mpa_req_if.sv
// ----------------------------------------------------------------------------
// mpa_req_if
// Request channel: valid/ready plus the input item fields.
// ----------------------------------------------------------------------------
interface mpa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [3:0]  slot;
	logic [3:0]  sound_id;
	logic [7:0]  priority_req;
	logic        looping;
	logic [15:0] min_play_ms;
	logic [15:0] replay_delay_ms;
	logic [15:0] fade_in_ms;
	logic [15:0] fade_out_ms;
	logic [7:0]  name_rank;
	logic [31:0] now_ms;
	logic        track_ended;

	modport source (output valid, opcode, slot, sound_id, priority_req, looping,
		min_play_ms, replay_delay_ms, fade_in_ms, fade_out_ms, name_rank, now_ms,
		track_ended, input ready);
	modport sink (input valid, opcode, slot, sound_id, priority_req, looping,
		min_play_ms, replay_delay_ms, fade_in_ms, fade_out_ms, name_rank, now_ms,
		track_ended, output ready);
endinterface

### rtl/mpa_res_if.sv
// ----------------------------------------------------------------------------
// mpa_res_if
// Result channel: valid/ready plus the result item fields.
// ----------------------------------------------------------------------------
interface mpa_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [3:0]  out_sound;
	logic [15:0] fade_ms;
	logic        out_looping;

	modport source (output valid, action, out_sound, fade_ms, out_looping,
		input ready);
	modport sink (input valid, action, out_sound, fade_ms, out_looping,
		output ready);
endinterface

### rtl/music_priority_arbiter_top.sv
// ----------------------------------------------------------------------------
// music_priority_arbiter_top
// Picks the music sound to play from a sound table and a source slot table.
// ----------------------------------------------------------------------------
// Define/add/remove/enable/disable and ticks while disabled load the result
//   register directly on acceptance.
// Update tick: CUR reads the current sound; unless min play holds, the scan
//   takes each slot through SLOT then CAND (chained slot-table read then
//   sound-table read via the single read ports); COMMIT loads the result.
// One item at a time; ready stays low while a tick is in progress.
// Reset (arst_n low, async): no slots, nothing playing, enabled, time rules on.
module music_priority_arbiter_top #(
	parameter int NUM_SLOTS  = mpa_pkg::NUM_SLOTS_DEF,
	parameter int NUM_SOUNDS = mpa_pkg::NUM_SOUNDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_data,
	mpa_req_if.sink      request,
	mpa_res_if.source    result
);

	localparam int SLW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SNW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
	localparam logic [SLW-1:0] LAST_SLOT = SLW'(NUM_SLOTS - 1);

	mpa_pkg::state_t state_q;

	logic            time_rules_q;
	logic            enabled_q;
	logic            playing_q;
	logic [SNW-1:0]  cur_snd_q;
	logic [31:0]     play_start_q;
	logic            was_stopped_q [NUM_SOUNDS];
	logic            slot_valid_q  [NUM_SLOTS];
	logic            slot_played_q [NUM_SLOTS];

	// per-tick working registers
	logic [31:0]     now_q;
	logic            ended_q;
	logic            hold_q;
	mpa_pkg::attr_t  cur_attr_q;
	mpa_pkg::attr_t  best_attr_q;
	logic [SNW-1:0]  best_snd_q;
	logic [SLW-1:0]  best_slot_q;
	logic            have_best_q;
	logic            found_q;
	logic [SLW-1:0]  idx_q;
	logic [SNW-1:0]  cand_snd_q;
	logic            cand_ok_q;

	// result register
	logic            out_v_q;
	mpa_pkg::action_t out_act_q;
	logic [3:0]      out_snd_q;
	logic [15:0]     out_fade_q;
	logic            out_loop_q;

	// memories
	mpa_pkg::attr_t  attr_rdata;
	mpa_pkg::attr_t  attr_wdata;
	logic            attr_we;
	logic [SNW-1:0]  snd_raddr;
	logic [31:0]     stop_rdata;
	logic            stop_we;
	logic [31:0]     stop_wdata;
	logic [SNW-1:0]  slot_rdata;
	logic            slotm_we;
	logic [SLW-1:0]  slot_raddr;

	logic            accept;
	logic            out_free;
	logic [SLW-1:0]  req_slot;
	logic [SNW-1:0]  req_snd;
	logic            slot_ok;
	logic            snd_ok;

	assign out_free = !out_v_q || result.ready;
	assign request.ready = (state_q == mpa_pkg::ST_IDLE) && out_free;
	assign accept = request.valid && request.ready;

	assign req_slot = SLW'(request.slot);
	assign req_snd  = SNW'(request.sound_id);
	assign slot_ok  = 32'(request.slot) < NUM_SLOTS;
	assign snd_ok   = 32'(request.sound_id) < NUM_SOUNDS;

	assign result.valid       = out_v_q;
	assign result.action      = out_act_q;
	assign result.out_sound   = out_snd_q;
	assign result.fade_ms     = out_fade_q;
	assign result.out_looping = out_loop_q;

	assign attr_wdata = '{prio: request.priority_req, loops: request.looping,
		min_play: request.min_play_ms, replay: request.replay_delay_ms,
		fade_in: request.fade_in_ms, fade_out: request.fade_out_ms,
		rank: request.name_rank};
	assign attr_we = accept && (request.opcode == mpa_pkg::OP_DEFINE) && snd_ok;
	assign slotm_we = accept && (request.opcode == mpa_pkg::OP_ADD) && slot_ok && snd_ok
		&& !slot_valid_q[req_slot];

	// sound tables are read at the current sound before the scan, then per candidate
	assign snd_raddr  = (state_q == mpa_pkg::ST_SLOT) ? SNW'(slot_rdata) : cur_snd_q;
	assign slot_raddr = (state_q == mpa_pkg::ST_CAND) ? SLW'(idx_q + 1'b1) : '0;

	mpa_ram #(.WIDTH($bits(mpa_pkg::attr_t)), .DEPTH(NUM_SOUNDS)) u_attr_ram (
		.clk(clk), .we(attr_we), .waddr(req_snd), .wdata(attr_wdata),
		.raddr(snd_raddr), .rdata(attr_rdata)
	);

	mpa_ram #(.WIDTH(32), .DEPTH(NUM_SOUNDS)) u_stop_ram (
		.clk(clk), .we(stop_we), .waddr(cur_snd_q), .wdata(stop_wdata),
		.raddr(snd_raddr), .rdata(stop_rdata)
	);

	mpa_ram #(.WIDTH(SNW), .DEPTH(NUM_SLOTS)) u_slot_ram (
		.clk(clk), .we(slotm_we), .waddr(req_slot), .wdata(req_snd),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	// --- shared compare unit: holds, holdoff and candidate ranking ---
	logic        hold_c;
	logic        holdoff_c;
	logic        take_c;
	logic        best_is_cur;
	logic        play_c;
	logic [15:0] xfade_c;

	always_comb begin
		hold_c = time_rules_q && playing_q &&
			({1'b0, now_q} <= ({1'b0, play_start_q} + 33'(attr_rdata.min_play)));
		holdoff_c = time_rules_q && was_stopped_q[cand_snd_q] &&
			({1'b0, now_q} <= ({1'b0, stop_rdata} + 33'(attr_rdata.replay)));
		best_is_cur = playing_q && (best_snd_q == cur_snd_q);
		take_c = 1'b0;
		if (cand_ok_q && !holdoff_c) begin
			if (!have_best_q) begin
				take_c = 1'b1;
			end else if (attr_rdata.prio < best_attr_q.prio) begin
				take_c = 1'b1;
			end else if (attr_rdata.prio == best_attr_q.prio) begin
				if (!attr_rdata.loops && best_attr_q.loops) begin
					take_c = 1'b1;
				end else if (attr_rdata.loops == best_attr_q.loops) begin
					take_c = !best_is_cur && (attr_rdata.rank > best_attr_q.rank);
				end
			end
		end
		play_c = !hold_q && have_best_q && !best_is_cur;
		xfade_c = best_attr_q.fade_in;
		if (playing_q && (cur_attr_q.fade_out < xfade_c)) begin
			xfade_c = cur_attr_q.fade_out;
		end
	end

	// stop-time writes: disable in idle, or a stop/crossfade at commit
	logic commit_go;
	logic halt_hard_c;
	logic halt_fade_c;

	assign commit_go   = (state_q == mpa_pkg::ST_COMMIT) && out_free;
	assign halt_hard_c = !hold_q && !play_c && playing_q && !cur_attr_q.loops && ended_q;
	assign halt_fade_c = !hold_q && !play_c && playing_q && !halt_hard_c && !found_q;

	always_comb begin
		stop_we    = 1'b0;
		stop_wdata = now_q;
		if (accept && (request.opcode == mpa_pkg::OP_DISABLE) && playing_q) begin
			stop_we    = 1'b1;
			stop_wdata = request.now_ms;
		end else if (commit_go && playing_q && (play_c || halt_hard_c || halt_fade_c)) begin
			stop_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpa_pkg::ST_IDLE;
			time_rules_q <= 1'b1;
			enabled_q    <= 1'b1;
			playing_q    <= 1'b0;
			cur_snd_q    <= '0;
			play_start_q <= '0;
			out_v_q      <= 1'b0;
			for (int i = 0; i < NUM_SOUNDS; i++) begin
				was_stopped_q[i] <= 1'b0;
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_valid_q[i]  <= 1'b0;
				slot_played_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				time_rules_q <= cfg_data;
			end
			if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				mpa_pkg::ST_IDLE: begin
					if (accept) begin
						out_v_q <= 1'b1;
						unique case (request.opcode)
							mpa_pkg::OP_DEFINE: begin
								if (snd_ok) begin
									was_stopped_q[req_snd] <= 1'b0;
								end
							end
							mpa_pkg::OP_ADD: begin
								if (slotm_we) begin
									slot_valid_q[req_slot]  <= 1'b1;
									slot_played_q[req_slot] <= 1'b0;
								end
							end
							mpa_pkg::OP_REMOVE: begin
								if (slot_ok) begin
									slot_valid_q[req_slot]  <= 1'b0;
									slot_played_q[req_slot] <= 1'b0;
								end
							end
							mpa_pkg::OP_TICK: begin
								if (enabled_q) begin
									out_v_q <= 1'b0;
									state_q <= mpa_pkg::ST_CUR;
								end
							end
							mpa_pkg::OP_ENABLE: begin
								enabled_q <= 1'b1;
							end
							mpa_pkg::OP_DISABLE: begin
								enabled_q <= 1'b0;
								if (playing_q) begin
									was_stopped_q[cur_snd_q] <= 1'b1;
									playing_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				mpa_pkg::ST_CUR: begin
					hold_q <= hold_c;
					state_q <= hold_c ? mpa_pkg::ST_COMMIT : mpa_pkg::ST_SLOT;
				end
				mpa_pkg::ST_SLOT: begin
					state_q <= mpa_pkg::ST_CAND;
				end
				mpa_pkg::ST_CAND: begin
					state_q <= (idx_q == LAST_SLOT) ? mpa_pkg::ST_COMMIT : mpa_pkg::ST_SLOT;
				end
				mpa_pkg::ST_COMMIT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= mpa_pkg::ST_IDLE;
						if (play_c) begin
							if (playing_q) begin
								was_stopped_q[cur_snd_q] <= 1'b1;
							end
							cur_snd_q    <= best_snd_q;
							playing_q    <= 1'b1;
							play_start_q <= now_q;
							if (!best_attr_q.loops) begin
								slot_played_q[best_slot_q] <= 1'b1;
							end
						end else if (halt_hard_c || halt_fade_c) begin
							was_stopped_q[cur_snd_q] <= 1'b1;
							playing_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= mpa_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload and scan working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= request.now_ms;
			ended_q <= request.track_ended;
			out_act_q  <= mpa_pkg::ACT_NONE;
			out_snd_q  <= '0;
			out_fade_q <= '0;
			out_loop_q <= 1'b0;
			if ((request.opcode == mpa_pkg::OP_DISABLE) && playing_q) begin
				out_act_q <= mpa_pkg::ACT_STOP;
			end
		end
		case (state_q)
			mpa_pkg::ST_CUR: begin
				cur_attr_q  <= attr_rdata;
				best_attr_q <= attr_rdata;
				best_snd_q  <= cur_snd_q;
				best_slot_q <= '0;
				have_best_q <= playing_q;
				found_q     <= 1'b0;
				idx_q       <= '0;
			end
			mpa_pkg::ST_SLOT: begin
				cand_snd_q <= SNW'(slot_rdata);
				cand_ok_q  <= slot_valid_q[idx_q] && !slot_played_q[idx_q];
				if (slot_valid_q[idx_q] && (SNW'(slot_rdata) == cur_snd_q)) begin
					found_q <= 1'b1;
				end
			end
			mpa_pkg::ST_CAND: begin
				if (take_c) begin
					have_best_q <= 1'b1;
					best_snd_q  <= cand_snd_q;
					best_slot_q <= idx_q;
					best_attr_q <= attr_rdata;
				end
				idx_q <= SLW'(idx_q + 1'b1);
			end
			mpa_pkg::ST_COMMIT: begin
				if (out_free) begin
					out_act_q  <= mpa_pkg::ACT_NONE;
					out_snd_q  <= '0;
					out_fade_q <= '0;
					out_loop_q <= 1'b0;
					if (play_c) begin
						out_act_q  <= mpa_pkg::ACT_PLAY;
						out_snd_q  <= 4'(best_snd_q);
						out_fade_q <= xfade_c;
						out_loop_q <= best_attr_q.loops;
					end else if (halt_hard_c) begin
						out_act_q <= mpa_pkg::ACT_STOP;
					end else if (halt_fade_c) begin
						out_act_q  <= mpa_pkg::ACT_STOP;
						out_fade_q <= cur_attr_q.fade_out;
					end
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		request.ready |-> (state_q == mpa_pkg::ST_IDLE))
		else $error("ready outside idle");
	a_play_sets_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_go && play_c) |=> playing_q)
		else $error("play issued without playing");
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpa_pkg::ST_CAND) |-> (idx_q <= LAST_SLOT))
		else $error("scan index out of range");
	a_commit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> (out_v_q && (state_q == mpa_pkg::ST_IDLE)))
		else $error("commit did not load a result");
`endif

endmodule

### rtl/mpa_ram.sv
// ----------------------------------------------------------------------------
// mpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### tb/sv/music_priority_arbiter_top_tb.sv
// ----------------------------------------------------------------------------
// music_priority_arbiter_top_tb
// Self-checking bench for the music arbiter. A directed table comes first,
// then random traffic in phases with and without idling on either side.
// Every accepted item is run through a local model of the sound and slot
// tables; each result is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module music_priority_arbiter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT      = mpa_pkg::NUM_SLOTS_DEF;
	localparam int NSND       = mpa_pkg::NUM_SOUNDS_DEF;
	localparam int HOLD_OFF   = 40;     // outlasts the longest tick
	localparam int STALL_LIM  = 5000;   // cycles with no item moving

	typedef struct packed {
		logic [2:0]  opcode;
		logic [3:0]  slot;
		logic [3:0]  sound_id;
		logic [7:0]  priority_req;
		logic        looping;
		logic [15:0] min_play_ms;
		logic [15:0] replay_delay_ms;
		logic [15:0] fade_in_ms;
		logic [15:0] fade_out_ms;
		logic [7:0]  name_rank;
		logic [31:0] now_ms;
		logic        track_ended;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  out_sound;
		logic [15:0] fade_ms;
		logic        out_looping;
	} music_out_t;

	// one directed row: item, and a typed answer where it is obvious
	typedef struct packed {
		cmd_t       cmd;
		logic       typed;
		music_out_t ans;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	mpa_req_if request ();
	mpa_res_if result ();

	music_priority_arbiter_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.request  (request),
		.result   (result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- model
	mpa_pkg::attr_t snd_tab [NSND];
	logic [31:0] last_stop [NSND];
	bit          was_stopped [NSND];
	bit          defined   [NSND];
	bit          sl_valid  [NSLOT];
	bit          sl_played [NSLOT];
	logic [3:0]  sl_sound  [NSLOT];
	bit          playing;
	logic [3:0]  cur_snd;
	logic [31:0] play_t0;
	bit          en;
	bit          rules_on;

	music_out_t  pending_q [$];
	bit          failed;
	int          stall_cnt;

	music_out_t  NOTHING;
	assign NOTHING = '{action: mpa_pkg::ACT_NONE, out_sound: 4'd0, fade_ms: 16'd0,
		out_looping: 1'b0};

	// stop what is playing; fade from its fade-out or hard
	function automatic music_out_t halt_music(logic [31:0] now, bit faded);
		music_out_t o;
		o = '{action: mpa_pkg::ACT_STOP, out_sound: 4'd0, fade_ms: 16'd0,
			out_looping: 1'b0};
		if (faded)
			o.fade_ms = snd_tab[cur_snd].fade_out;
		last_stop[cur_snd] = now;
		was_stopped[cur_snd] = 1'b1;
		playing = 1'b0;
		return o;
	endfunction

	function automatic music_out_t arbitrate(logic [31:0] now, bit ended);
		music_out_t o;
		bit         have;
		bit         found;
		logic [3:0] best;
		logic [3:0] c;
		int         best_slot;
		mpa_pkg::attr_t a;
		mpa_pkg::attr_t b;
		logic [15:0] xf;
		o = NOTHING;
		have = playing;
		best = cur_snd;
		best_slot = 0;
		found = 1'b0;
		// minimum play time still running
		if (rules_on && playing &&
				{1'b0, now} <= {1'b0, play_t0} + {17'd0, snd_tab[cur_snd].min_play})
			return o;
		for (int s = 0; s < NSLOT; s++) begin
			if (!sl_valid[s] || sl_played[s])
				continue;
			c = sl_sound[s];
			a = snd_tab[c];
			if (rules_on && was_stopped[c] &&
					{1'b0, now} <= {1'b0, last_stop[c]} + {17'd0, a.replay})
				continue;
			if (!have) begin
				have = 1'b1;
				best = c;
				best_slot = s;
				continue;
			end
			b = snd_tab[best];
			if (a.prio < b.prio) begin
				best = c;
				best_slot = s;
			end else if (a.prio == b.prio) begin
				if (!a.loops && b.loops) begin
					best = c;
					best_slot = s;
				end else if (a.loops == b.loops) begin
					if (!(playing && best == cur_snd) && a.rank > b.rank) begin
						best = c;
						best_slot = s;
					end
				end
			end
		end
		if (have && !(playing && best == cur_snd)) begin
			xf = snd_tab[best].fade_in;
			if (playing) begin
				if (snd_tab[cur_snd].fade_out < xf)
					xf = snd_tab[cur_snd].fade_out;
				last_stop[cur_snd] = now;
				was_stopped[cur_snd] = 1'b1;
			end
			o = '{action: mpa_pkg::ACT_PLAY, out_sound: best, fade_ms: xf,
				out_looping: snd_tab[best].loops};
			cur_snd = best;
			playing = 1'b1;
			play_t0 = now;
			if (!snd_tab[best].loops)
				sl_played[best_slot] = 1'b1;
		end else if (playing) begin
			if (!snd_tab[cur_snd].loops && ended) begin
				o = halt_music(now, 1'b0);
			end else begin
				for (int s = 0; s < NSLOT; s++)
					if (sl_valid[s] && sl_sound[s] == cur_snd)
						found = 1'b1;
				if (!found)
					o = halt_music(now, 1'b1);
			end
		end
		return o;
	endfunction

	function automatic music_out_t apply_cmd(cmd_t r);
		music_out_t o;
		o = NOTHING;
		unique case (r.opcode)
			mpa_pkg::OP_DEFINE: begin
				snd_tab[r.sound_id] = '{prio: r.priority_req, loops: r.looping,
					min_play: r.min_play_ms, replay: r.replay_delay_ms,
					fade_in: r.fade_in_ms, fade_out: r.fade_out_ms, rank: r.name_rank};
				was_stopped[r.sound_id] = 1'b0;
				defined[r.sound_id] = 1'b1;
			end
			mpa_pkg::OP_ADD: begin
				if (!sl_valid[r.slot]) begin
					sl_valid[r.slot] = 1'b1;
					sl_sound[r.slot] = r.sound_id;
					sl_played[r.slot] = 1'b0;
				end
			end
			mpa_pkg::OP_REMOVE: begin
				sl_valid[r.slot] = 1'b0;
				sl_played[r.slot] = 1'b0;
			end
			mpa_pkg::OP_TICK: begin
				if (en)
					o = arbitrate(r.now_ms, r.track_ended);
			end
			mpa_pkg::OP_ENABLE: en = 1'b1;
			mpa_pkg::OP_DISABLE: begin
				if (playing)
					o = halt_music(r.now_ms, 1'b0);
				en = 1'b0;
			end
			default: ;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------- sender
	int send_idle_pct;
	int recv_stall_pct;

	// present one item at the falling edge, hold it until it is taken
	task automatic send_cmd(cmd_t r, bit typed, music_out_t ans);
		music_out_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			request.valid = 1'b0;
			@(negedge clk);
		end
		request.valid           = 1'b1;
		request.opcode          = r.opcode;
		request.slot            = r.slot;
		request.sound_id        = r.sound_id;
		request.priority_req    = r.priority_req;
		request.looping         = r.looping;
		request.min_play_ms     = r.min_play_ms;
		request.replay_delay_ms = r.replay_delay_ms;
		request.fade_in_ms      = r.fade_in_ms;
		request.fade_out_ms     = r.fade_out_ms;
		request.name_rank       = r.name_rank;
		request.now_ms          = r.now_ms;
		request.track_ended     = r.track_ended;
		do
			@(posedge clk);
		while (!request.ready);
		p = apply_cmd(r);
		pending_q.push_back(typed ? ans : p);
		@(negedge clk);
	endtask

	// registers move only with nothing in flight
	task automatic set_time_rules(bit v);
		request.valid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (HOLD_OFF) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		rules_on = v;
	endtask

	// ---------------------------------------------------------------- random items
	logic [31:0] sim_ms;

	function automatic logic [15:0] rnd_ms();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'hFFFF;
			2: return 16'd0;
			default: return 16'($urandom_range(1500));
		endcase
	endfunction

	function automatic cmd_t rnd_cmd();
		cmd_t r;
		int   pick;
		int   tries;
		r = cmd_t'({$urandom, $urandom, $urandom, $urandom});
		pick = $urandom_range(99);
		// time mostly runs forward; now and then it jumps anywhere
		if ($urandom_range(49) == 0)
			sim_ms = $urandom;
		else
			sim_ms = sim_ms + $urandom_range(2500);
		r.now_ms = sim_ms;
		r.track_ended = $urandom_range(3) == 0;
		if (pick < 14)       r.opcode = mpa_pkg::OP_DEFINE;
		else if (pick < 34)  r.opcode = mpa_pkg::OP_ADD;
		else if (pick < 44)  r.opcode = mpa_pkg::OP_REMOVE;
		else if (pick < 92)  r.opcode = mpa_pkg::OP_TICK;
		else if (pick < 95)  r.opcode = mpa_pkg::OP_ENABLE;
		else if (pick < 97)  r.opcode = mpa_pkg::OP_DISABLE;
		else                 r.opcode = 3'($urandom_range(6, 7));
		if (r.opcode == mpa_pkg::OP_DEFINE) begin
			r.min_play_ms     = rnd_ms();
			r.replay_delay_ms = rnd_ms();
			r.fade_in_ms      = 16'($urandom);
			r.fade_out_ms     = 16'($urandom);
			if ($urandom_range(1))
				r.priority_req = 8'($urandom_range(3));
			if ($urandom_range(1))
				r.name_rank = 8'($urandom_range(3));
		end
		if (r.opcode == mpa_pkg::OP_ADD) begin
			// only sounds already defined go into a slot
			tries = 0;
			while (!defined[r.sound_id] && tries < 64) begin
				r.sound_id = 4'($urandom);
				tries++;
			end
			if (!defined[r.sound_id])
				r.opcode = mpa_pkg::OP_DEFINE;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- directed table
	function automatic cmd_t mk(logic [2:0] op, logic [3:0] sl, logic [3:0] sid,
			logic [31:0] now, logic ended);
		cmd_t r;
		r = '0;
		r.opcode = op;
		r.slot = sl;
		r.sound_id = sid;
		r.now_ms = now;
		r.track_ended = ended;
		return r;
	endfunction

	function automatic cmd_t mk_def(logic [3:0] sid, logic [7:0] pr, logic lp,
			logic [15:0] mn, logic [15:0] rp, logic [15:0] fi, logic [15:0] fo,
			logic [7:0] rk);
		cmd_t r;
		r = mk(mpa_pkg::OP_DEFINE, 4'd0, sid, 32'd0, 1'b0);
		r.priority_req = pr;
		r.looping = lp;
		r.min_play_ms = mn;
		r.replay_delay_ms = rp;
		r.fade_in_ms = fi;
		r.fade_out_ms = fo;
		r.name_rank = rk;
		return r;
	endfunction

	row_t dir_rows [$];

	task automatic row(cmd_t c, bit typed);
		dir_rows.push_back('{cmd: c, typed: typed, ans: NOTHING});
	endtask

	task automatic build_table();
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'd0, 1'b0), 1);          // empty table
		row(mk(3'd6, 4'd0, 4'd0, 32'd0, 1'b0), 1);                      // unknown ops
		row(mk(3'd7, 4'hF, 4'hF, 32'hFFFF_FFFF, 1'b1), 1);
		row(mk_def(4'd0, 8'hFF, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'hFF), 1);
		row(mk_def(4'd15, 8'h00, 1'b0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 8'h00), 1);
		row(mk_def(4'd1, 8'h00, 1'b1, 16'd0, 16'd0, 16'd100, 16'd200, 8'd7), 1);
		row(mk(mpa_pkg::OP_ADD, 4'd15, 4'd0, 32'd0, 1'b0), 1);
		row(mk(mpa_pkg::OP_ADD, 4'd0, 4'd1, 32'd0, 1'b0), 1);
		row(mk(mpa_pkg::OP_ADD, 4'd0, 4'd15, 32'd0, 1'b0), 1);          // slot already filled
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'd10, 1'b0), 0);
		row(mk(mpa_pkg::OP_ADD, 4'd3, 4'd15, 32'd0, 1'b0), 1);
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'd20, 1'b0), 0);         // one-shot wins tie
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'd30, 1'b1), 0);         // min play holds
		row(mk(mpa_pkg::OP_REMOVE, 4'd3, 4'd0, 32'd0, 1'b0), 1);
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1), 0);  // top of time range
		row(mk(mpa_pkg::OP_REMOVE, 4'd9, 4'd0, 32'd0, 1'b0), 1);        // empty slot
		row(mk(mpa_pkg::OP_DISABLE, 4'd0, 4'd0, 32'hFFFF_FFF0, 1'b0), 0);
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0), 1);  // disabled: silent
		row(mk(mpa_pkg::OP_DISABLE, 4'd0, 4'd0, 32'd5, 1'b0), 1);       // nothing playing
		row(mk(mpa_pkg::OP_ENABLE, 4'd0, 4'd0, 32'd0, 1'b0), 1);
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0), 0);
		row(mk_def(4'd1, 8'h01, 1'b0, 16'd5, 16'd5, 16'd9, 16'd3, 8'd1), 1);
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'd100, 1'b1), 0);        // redefined while playing
		row(mk(mpa_pkg::OP_REMOVE, 4'd0, 4'd0, 32'd0, 1'b0), 1);
		row(mk(mpa_pkg::OP_TICK, 4'd0, 4'd0, 32'd200, 1'b0), 0);
	endtask

	// ---------------------------------------------------------------- checker
	always @(negedge clk)
		result.ready = $urandom_range(99) >= recv_stall_pct;

	always @(posedge clk) begin
		music_out_t got;
		music_out_t want;
		if (result.valid === 1'b1 && result.ready) begin
			got = '{action: result.action, out_sound: result.out_sound,
				fade_ms: result.fade_ms, out_looping: result.out_looping};
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				failed = 1'b1;
			end else begin
				want = pending_q.pop_front();
				if (got.action !== want.action)
					$display("%0t: action exp %0d got %0d", $time, want.action, got.action);
				if (got.out_sound !== want.out_sound)
					$display("%0t: out_sound exp %0d got %0d", $time, want.out_sound,
						got.out_sound);
				if (got.fade_ms !== want.fade_ms)
					$display("%0t: fade_ms exp %0d got %0d", $time, want.fade_ms,
						got.fade_ms);
				if (got.out_looping !== want.out_looping)
					$display("%0t: out_looping exp %0d got %0d", $time, want.out_looping,
						got.out_looping);
				if (got !== want)
					failed = 1'b1;
			end
		end
	end

	// watchdog: nothing moving on either channel for too long
	always @(posedge clk) begin
		if ((request.valid && request.ready) || (result.valid && result.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIM) begin
			$display("%0t: watchdog, %0d results outstanding", $time, pending_q.size());
			$display("** music_priority_arbiter_top: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main flow
	initial begin
		int idle_tab  [4] = '{0, 52, 0, 36};
		int stall_tab [4] = '{0, 0, 52, 36};
		row_t rw;
		failed = 1'b0;
		stall_cnt = 0;
		sim_ms = 32'd0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		request.valid = 1'b0;
		request.opcode = mpa_pkg::OP_ENABLE;
		{request.slot, request.sound_id, request.priority_req, request.looping,
			request.min_play_ms, request.replay_delay_ms, request.fade_in_ms,
			request.fade_out_ms, request.name_rank, request.now_ms,
			request.track_ended} = '0;
		result.ready = 1'b0;

		// model state after reset
		for (int i = 0; i < NSND; i++) begin
			snd_tab[i] = '0;
			last_stop[i] = '0;
			was_stopped[i] = 1'b0;
			defined[i] = 1'b0;
		end
		for (int i = 0; i < NSLOT; i++) begin
			sl_valid[i] = 1'b0;
			sl_played[i] = 1'b0;
			sl_sound[i] = '0;
		end
		playing = 1'b0;
		cur_snd = '0;
		play_t0 = '0;
		en = 1'b1;
		rules_on = 1'b1;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, time rules at reset value
		build_table();
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			send_cmd(rw.cmd, rw.typed, rw.ans);
		end
		sim_ms = 32'd1000;

		// random phases: each idling mix once with rules off, once with rules on
		for (int ph = 0; ph < 8; ph++) begin
			set_time_rules(ph >= 4);
			send_idle_pct = idle_tab[ph % 4];
			recv_stall_pct = stall_tab[ph % 4];
			for (int n = 0; n < 170; n++)
				send_cmd(rnd_cmd(), 1'b0, NOTHING);
		end
		request.valid = 1'b0;
		recv_stall_pct = 0;

		wait (pending_q.size() == 0);
		repeat (HOLD_OFF) @(posedge clk);
		if (!failed)
			$display("** music_priority_arbiter_top: PASSED **");
		else
			$display("** music_priority_arbiter_top: FAILED **");
		$finish;
	end

endmodule
